>>> src/upd_pkg.sv
package upd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned NibW  = 4;

    localparam logic [ByteW-1:0] PCT_CHAR   = 8'h25;
    localparam logic [ByteW-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [ByteW-1:0] SPACE_CHAR = 8'h20;
    localparam logic [ByteW-1:0] MINUS_CHAR = 8'h2D;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_C0   = 2'd1,
        PH_C1   = 2'd2
    } phase_t;

    typedef struct packed {
        logic             is_hex;
        logic [NibW-1:0]  value;
    } hex_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             has_byte;
        logic             end_of_string;
    } res_t;

    function automatic hex_t hex_digit(input logic [ByteW-1:0] c);
        hex_t h;
        h.is_hex = 1'b1;
        h.value  = '0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = NibW'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            h.value = NibW'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            h.value = NibW'(c - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return (c == SPACE_CHAR) || (c inside {[8'h09:8'h0D]});
    endfunction

    // strtoul-style value of the two escape characters, truncated to a byte
    function automatic logic [ByteW-1:0] escape_value(input logic [ByteW-1:0] c0,
                                                      input logic [ByteW-1:0] c1);
        hex_t d0;
        hex_t d1;
        logic [ByteW-1:0] v;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        if (d0.is_hex) begin
            v = d1.is_hex ? {d0.value, d1.value} : {{(ByteW-NibW){1'b0}}, d0.value};
        end else if (!d1.is_hex) begin
            v = '0;
        end else if (is_blank(c0) || (c0 == PLUS_CHAR)) begin
            v = {{(ByteW-NibW){1'b0}}, d1.value};
        end else if (c0 == MINUS_CHAR) begin
            v = ByteW'(0) - {{(ByteW-NibW){1'b0}}, d1.value};
        end else begin
            v = '0;
        end
        return v;
    endfunction

endpackage

>>> src/url_percent_decoder_top.sv
// Channel  Direction  Payload
// s_*      in         tdata[7:0] in_byte, tlast is_last
// m_*      out        tdata[7:0] out_byte, tuser[0] has_byte, tlast end_of_string
//
// One byte per cycle sustained unless m stalls; results pass both registers.
// Path: input register, escape decode against the phase register, result register.
// A '%' or first escape byte that is not last gives no result and still moves on.
// Reset (aresetn low, synchronous) empties both registers and closes any escape.
// A stalled m side holds the result; s_tready drops if the held input must emit.
module url_percent_decoder_top import upd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] has_byte
    output logic       m_tlast
);

    logic             in_valid_reg, in_valid_next;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;
    logic             emit;
    logic             out_free;
    logic             advance;
    logic             s_xfer;
    res_t             res;
    res_t             res_out;

    // items without a result move on without claiming the output register
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    upd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_byte (in_byte_reg),
        .is_last (in_last_reg),
        .emit    (emit),
        .res     (res)
    );

    upd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_out)
    );

    assign m_tdata    = res_out.out_byte;
    assign m_tuser[0] = res_out.has_byte;
    assign m_tlast    = res_out.end_of_string;

endmodule

>>> src/upd_decode.sv
module upd_decode import upd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [ByteW-1:0] in_byte,
    input  logic             is_last,
    output logic             emit,
    output res_t             res
);

    phase_t           phase_reg,  phase_next;
    logic [ByteW-1:0] c0_reg,     c0_next;
    logic             has;
    logic [ByteW-1:0] val;

    always_comb begin
        phase_next = phase_reg;
        c0_next    = c0_reg;
        has        = 1'b0;
        val        = '0;
        case (phase_reg)
            PH_C0: begin
                c0_next    = in_byte;
                phase_next = PH_C1;
            end
            PH_C1: begin
                val        = escape_value(c0_reg, in_byte);
                has        = 1'b1;
                phase_next = PH_IDLE;
                c0_next    = '0;
            end
            default: begin
                if (in_byte == PCT_CHAR) begin
                    phase_next = PH_C0;
                end else begin
                    has        = 1'b1;
                    val        = (in_byte == PLUS_CHAR) ? SPACE_CHAR : in_byte;
                    phase_next = PH_IDLE;
                end
            end
        endcase
        // end of string drops any open escape
        if (is_last) begin
            phase_next = PH_IDLE;
            c0_next    = '0;
        end
    end

    assign emit              = has | is_last;
    assign res.out_byte      = val;
    assign res.has_byte      = has;
    assign res.end_of_string = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            c0_reg    <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            c0_reg    <= c0_next;
        end
    end

endmodule

>>> src/upd_out_reg.sv
module upd_out_reg import upd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  res_t res,
    output logic free,
    output logic m_tvalid,
    input  logic m_tready,
    output res_t res_out
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule

>>> src/upd_checker.sv
module upd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // a waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input changed while waiting");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a result without a byte only closes a string
    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("byte-less result not at end of string");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("byte-less result carries data");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
